/* design/dfcmp_pkg.sv */
package dfcmp_pkg;

    localparam int MAX_NODES = 65536;
    localparam int NODE_W    = $clog2(MAX_NODES + 1);
    localparam int DEG_W     = 17;
    localparam int SUM_W     = 33;
    localparam int M_W       = SUM_W + 2;
    localparam int RES_W     = 30;
    localparam int CNT_W     = $clog2(RES_W);

    localparam logic [RES_W-1:0] MOD_P      = 30'd1000000007;
    localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;
    localparam logic [RES_W:0]   MOD_P2     = 31'd2000000014;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(RES_W - 1);

endpackage

/* design/dfcmp_mulmod.sv */
module dfcmp_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dfcmp_pkg::RES_W-1:0]   i_a,
    input  logic [dfcmp_pkg::RES_W-1:0]   i_b,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [dfcmp_pkg::RES_W-1:0]   o_prod
);

    logic                          r_busy;
    logic                          r_done;
    logic [dfcmp_pkg::CNT_W-1:0]   r_cnt;
    logic [dfcmp_pkg::RES_W-1:0]   r_acc;
    logic [dfcmp_pkg::RES_W-1:0]   r_a;
    logic [dfcmp_pkg::RES_W-1:0]   r_b;
    logic [dfcmp_pkg::RES_W+1:0]   w_sum;
    logic [dfcmp_pkg::RES_W-1:0]   n_acc;

    // double and add one multiplier bit, then fold back below the modulus
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0}
              + (r_b[dfcmp_pkg::RES_W-1] ? {2'b00, r_a} : '0);
        if (w_sum >= {1'b0, dfcmp_pkg::MOD_P2}) begin
            n_acc = dfcmp_pkg::RES_W'(w_sum - {1'b0, dfcmp_pkg::MOD_P2});
        end else if (w_sum >= {2'b00, dfcmp_pkg::MOD_P}) begin
            n_acc = dfcmp_pkg::RES_W'(w_sum - {2'b00, dfcmp_pkg::MOD_P});
        end else begin
            n_acc = dfcmp_pkg::RES_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dfcmp_pkg::CNT_TOP;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[dfcmp_pkg::RES_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* design/degree_fill_count_mod_prime.sv */
// Degree fill counter, result modulo 1000000007.
// Input channel (i_valid/o_ready): one request per node, i_degree is the known
// degree or -1 (any value not above zero counts as unknown); i_last_entry ends
// the list. Entries are taken one per cycle while the block is loading.
// Entries beyond the node capacity are dropped, but their last mark still
// closes the list.
// After the last entry o_ready stays low while one shared serial modular
// multiplier forms C(m-1, k-1) and the Fermat inverse, k being the count of
// unknown entries; no product is formed when k is 0 or m is below k.
// Output channel (o_valid/i_ready): one request o_ways_mod per list, held in
// an output register. Loading of the next list goes on while that result
// waits; a finished second result waits inside until the register is free.
// Reset (synchronous, active low) clears the counters and drops any pending
// work and result.
module degree_fill_count_mod_prime (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [16:0]            i_degree,
    input  logic                          i_last_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [29:0]                   o_ways_mod
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_LOOP = 4'd2;
    localparam logic [3:0] S_NUMW = 4'd3;
    localparam logic [3:0] S_DENW = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_SQW  = 4'd6;
    localparam logic [3:0] S_PM   = 4'd7;
    localparam logic [3:0] S_PMW  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_FINW = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam int NW = dfcmp_pkg::NODE_W;
    localparam int RW = dfcmp_pkg::RES_W;

    logic [3:0]                      r_state;
    logic [NW-1:0]                   r_node_count;
    logic [dfcmp_pkg::SUM_W-1:0]     r_known_sum;
    logic [NW-1:0]                   r_unknown_count;
    logic [NW-1:0]                   r_r;
    logic [NW-1:0]                   r_s;
    logic [NW-1:0]                   r_i;
    logic [RW-1:0]                   r_num;
    logic [RW-1:0]                   r_den;
    logic [RW-1:0]                   r_pow;
    logic [RW-1:0]                   r_res;
    logic [dfcmp_pkg::CNT_W-1:0]     r_ecnt;
    logic                            r_out_valid;
    logic [RW-1:0]                   r_out;

    logic                            w_in_acc;
    logic                            w_deg_pos;
    logic [NW:0]                     w_two_n;
    logic signed [dfcmp_pkg::M_W-1:0] w_m;
    logic                            w_m_lt_k;

    logic                            w_start;
    logic [RW-1:0]                   w_a;
    logic [RW-1:0]                   w_b;
    logic                            w_mul_busy;
    logic                            w_mul_done;
    logic [RW-1:0]                   w_prod;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_acc  = i_valid && o_ready;
    assign w_deg_pos = !i_degree[16] && (i_degree != '0);

    assign w_two_n = {r_node_count - 1'b1, 1'b0};
    assign w_m = $signed({{(dfcmp_pkg::M_W - NW - 1){1'b0}}, w_two_n})
               - $signed({2'b00, r_known_sum});
    assign w_m_lt_k = w_m < $signed({{(dfcmp_pkg::M_W - NW){1'b0}}, r_unknown_count});

    always_comb begin
        w_start = 1'b0;
        w_a     = r_num;
        w_b     = RW'(r_r - r_i);
        case (r_state)
            S_LOOP: begin
                w_start = (r_i != r_s);
            end
            S_NUMW: begin
                w_start = w_mul_done;
                w_a     = r_den;
                w_b     = RW'(r_i + 1'b1);
            end
            S_SQ: begin
                w_start = 1'b1;
                w_a     = r_pow;
                w_b     = r_pow;
            end
            S_PM: begin
                w_start = dfcmp_pkg::FERMAT_EXP[r_ecnt];
                w_a     = r_pow;
                w_b     = r_den;
            end
            S_FIN: begin
                w_start = 1'b1;
                w_a     = r_num;
                w_b     = r_pow;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    dfcmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_node_count    <= '0;
            r_known_sum     <= '0;
            r_unknown_count <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_node_count < NW'(dfcmp_pkg::MAX_NODES)) begin
                            r_node_count <= r_node_count + 1'b1;
                            if (w_deg_pos) begin
                                r_known_sum <= r_known_sum
                                    + {{(dfcmp_pkg::SUM_W - 16){1'b0}}, i_degree[15:0]};
                            end else begin
                                r_unknown_count <= r_unknown_count + 1'b1;
                            end
                        end
                        if (i_last_entry) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_node_count    <= '0;
                    r_known_sum     <= '0;
                    r_unknown_count <= '0;
                    if (r_unknown_count == '0) begin
                        r_state <= S_DONE;
                    end else if (w_m_lt_k) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (r_i == r_s) begin
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_NUMW;
                    end
                end
                S_NUMW: begin
                    if (w_mul_done) begin
                        r_state <= S_DENW;
                    end
                end
                S_DENW: begin
                    if (w_mul_done) begin
                        r_state <= S_LOOP;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    if (w_mul_done) begin
                        r_state <= S_PM;
                    end
                end
                S_PM: begin
                    if (dfcmp_pkg::FERMAT_EXP[r_ecnt]) begin
                        r_state <= S_PMW;
                    end else if (r_ecnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_PMW: begin
                    if (w_mul_done) begin
                        r_state <= (r_ecnt == '0) ? S_FIN : S_SQ;
                    end
                end
                S_FIN: begin
                    r_state <= S_FINW;
                end
                S_FINW: begin
                    if (w_mul_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CHK: begin
                r_r    <= NW'(w_m - 1'b1);
                r_s    <= r_unknown_count - 1'b1;
                r_i    <= '0;
                r_num  <= RW'(1);
                r_den  <= RW'(1);
                r_pow  <= RW'(1);
                r_ecnt <= dfcmp_pkg::CNT_TOP;
                if (r_unknown_count == '0) begin
                    r_res <= RW'(w_m == '0);
                end else begin
                    r_res <= '0;
                end
            end
            S_NUMW: begin
                if (w_mul_done) begin
                    r_num <= w_prod;
                end
            end
            S_DENW: begin
                if (w_mul_done) begin
                    r_den <= w_prod;
                    r_i   <= r_i + 1'b1;
                end
            end
            S_SQW: begin
                if (w_mul_done) begin
                    r_pow <= w_prod;
                end
            end
            S_PM: begin
                if (!dfcmp_pkg::FERMAT_EXP[r_ecnt] && r_ecnt != '0) begin
                    r_ecnt <= r_ecnt - 1'b1;
                end
            end
            S_PMW: begin
                if (w_mul_done) begin
                    r_pow <= w_prod;
                    if (r_ecnt != '0) begin
                        r_ecnt <= r_ecnt - 1'b1;
                    end
                end
            end
            S_FINW: begin
                if (w_mul_done) begin
                    r_res <= w_prod;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_ways_mod = r_out;

`ifndef ASSERT_OFF
    a_res_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ways_mod < dfcmp_pkg::MOD_P))
        else $error("result not reduced below the modulus");

    a_chk_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> $past(w_in_acc && i_last_entry))
        else $error("evaluation entered without a closing request");

    a_mul_idle_when_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_CHK) |-> !w_mul_busy)
        else $error("multiplier busy outside the computation");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP || r_state == S_NUMW || r_state == S_DENW) |-> (r_i <= r_s))
        else $error("product loop ran past its count");
`endif

endmodule

/* tb/testbench.sv */
module testbench;

    class fill_scoreboard;
        longint unsigned node_total;
        longint unsigned degree_sum;
        longint unsigned unknown_total;
        logic [dfcmp_pkg::RES_W-1:0] ways_q[$];
        int mismatches;
        int lists_done;
        int nonzero_lists;
        longint unsigned widest_k;

        function logic [dfcmp_pkg::RES_W-1:0] count_ways(longint m, longint unsigned k);
            longint unsigned p;
            longint unsigned top;
            longint unsigned num;
            longint unsigned den;
            longint unsigned inv;
            longint unsigned base;
            longint unsigned e;
            longint unsigned i;
            p = 64'(dfcmp_pkg::MOD_P);
            if (k == 0) return (m == 0) ? dfcmp_pkg::RES_W'(1) : '0;
            if (m < longint'(k)) return '0;
            top = m - 1;
            num = 1;
            den = 1;
            for (i = 0; i < k - 1; i++) begin
                num = num * ((top - i) % p) % p;
                den = den * ((i + 1) % p) % p;
            end
            inv = 1;
            base = den;
            e = 64'(dfcmp_pkg::FERMAT_EXP);
            while (e != 0) begin
                if ((e & 1) != 0) inv = inv * base % p;
                base = base * base % p;
                e = e >> 1;
            end
            return dfcmp_pkg::RES_W'(num * inv % p);
        endfunction

        function void note_entry(logic signed [dfcmp_pkg::DEG_W-1:0] deg, logic last);
            longint m;
            if (node_total < dfcmp_pkg::MAX_NODES) begin
                node_total++;
                if (deg > 0) degree_sum += deg;
                else unknown_total++;
            end
            if (last) begin
                m = 2 * (longint'(node_total) - 1) - longint'(degree_sum);
                ways_q.push_back(count_ways(m, unknown_total));
                if (unknown_total > widest_k) widest_k = unknown_total;
                node_total = 0;
                degree_sum = 0;
                unknown_total = 0;
            end
        endfunction

        function void check_ways(logic [dfcmp_pkg::RES_W-1:0] got);
            logic [dfcmp_pkg::RES_W-1:0] want;
            if (ways_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: ways_mod %0d arrived with no list pending", got);
            end else begin
                want = ways_q.pop_front();
                lists_done++;
                if (want != 0) nonzero_lists++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: list %0d ways_mod expected %0d, got %0d",
                                 lists_done, want, got);
                end
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic signed [dfcmp_pkg::DEG_W-1:0] i_degree = '0;
    logic                               i_last_entry = 1'b0;
    logic                               i_ready = 1'b0;
    logic                               o_ready;
    logic                               o_valid;
    logic [dfcmp_pkg::RES_W-1:0]        o_ways_mod;
    logic                               calm = 1'b0;
    int                                 requests_sent = 0;
    fill_scoreboard                     sb = new;

    degree_fill_count_mod_prime dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_degree     (i_degree),
        .i_last_entry (i_last_entry),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ways_mod   (o_ways_mod)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_ways(o_ways_mod);
        i_ready <= calm || ($urandom_range(99) >= 9);
    end

    task automatic send_entry(input int deg, input logic last);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_degree     <= dfcmp_pkg::DEG_W'(deg);
        i_last_entry <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_entry(dfcmp_pkg::DEG_W'(deg), last);
        requests_sent++;
    endtask

    task automatic send_list(input int degs[$]);
        foreach (degs[j]) send_entry(degs[j], j == degs.size() - 1);
    endtask

    task automatic hold_off();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.ways_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int list[$];
        int len;
        int k;
        int left;
        int used;
        int idx;
        int i;
        int list_idx;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        list = '{1, 1};
        send_list(list);
        list = '{65535, 65535};
        send_list(list);
        list = '{-1};
        send_list(list);
        list = '{0, -65536, 2};
        send_list(list);
        list = '{1, 1, 1};
        send_list(list);
        list = '{-1, -1, -1, -1, 1};
        send_list(list);
        list = '{-2, 3, -1, 1};
        send_list(list);
        list = '{5, -1, -1};
        send_list(list);
        hold_off();

        list_idx = 0;
        while (requests_sent < 1250) begin
            calm <= (list_idx >= 15 && list_idx < 40);
            list.delete();
            if ($urandom_range(99) < 75) begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 300)
                                                   : $urandom_range(2, 12);
                k = $urandom_range(0, len);
                left = k;
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(1, len - i) <= left) begin
                        left--;
                        case ($urandom_range(0, 9))
                            0: list.push_back(0);
                            1: list.push_back(-int'($urandom_range(2, 65536)));
                            default: list.push_back(-1);
                        endcase
                    end else begin
                        list.push_back(1);
                    end
                end
                if (k < len) begin
                    used = (k == 0 && $urandom_range(0, 1) == 1) ? len - 2
                                                                 : $urandom_range(0, len - 2);
                    repeat (used) begin
                        idx = $urandom_range(0, len - 1);
                        while (list[idx] <= 0) idx = (idx + 1) % len;
                        list[idx] = list[idx] + 1;
                    end
                end
            end else begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0: list.push_back(int'($urandom_range(0, 131071)) - 65536);
                        1: list.push_back(-1);
                        2: list.push_back($urandom_range(1, 4));
                        default: list.push_back($urandom_range(0, 65535));
                    endcase
                end
            end
            send_list(list);
            list_idx++;
        end
        calm <= 1'b0;
        hold_off();
        repeat (2500) @(posedge i_clk);

        $display("Checked %0d degree lists, %0d with a nonzero count, up to %0d unknowns in one.",
                 sb.lists_done, sb.nonzero_lists, sb.widest_k);
        $display("Sent %0d degree requests, degrees spread over the full signed input range.",
                 requests_sent);
        if (sb.mismatches == 0 && sb.ways_q.size() == 0) begin
            $display("** degree_fill_count_mod_prime: PASSED **");
        end else begin
            $display("** degree_fill_count_mod_prime: FAILED **");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("** degree_fill_count_mod_prime: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
design/dfcmp_pkg.sv
design/dfcmp_mulmod.sv
design/degree_fill_count_mod_prime.sv
tb/testbench.sv
